// ----- design/tnt_pkg.sv -----
// Shared types and constants for the triangle normal and tangent engine.
// Used by tnt_norm, tnt_face, the top level and the testbench; depends on nothing.
package tnt_pkg;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TRI  = 1'b1;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMALS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TANGENTS = 1'b1;

	localparam int UNIT_ONE = 16384;

	typedef logic signed [15:0] fix16_t;
	typedef logic [9:0] vidx_t;
	typedef logic signed [35:0] vec_t;

	typedef struct packed {
		logic   kind;
		vidx_t  vertex_slot;
		fix16_t pos_x;
		fix16_t pos_y;
		fix16_t pos_z;
		fix16_t tex_u;
		fix16_t tex_v;
		vidx_t  corner_a;
		vidx_t  corner_b;
		vidx_t  corner_c;
	} req_t;

	typedef struct packed {
		vidx_t  target_vertex;
		fix16_t normal_x;
		fix16_t normal_y;
		fix16_t normal_z;
		fix16_t tangent_x;
		fix16_t tangent_y;
		fix16_t tangent_z;
		logic   last_corner;
	} res_t;

	typedef struct packed {
		fix16_t [2:0] pos;
		fix16_t [1:0] tex;
	} vert_t;

	typedef struct packed {
		vidx_t [2:0] corner;
		vert_t [2:0] vert;
	} tri_t;

	typedef struct packed {
		vidx_t  [2:0] corner;
		fix16_t [2:0] nrm;
		fix16_t [2:0] tan;
	} face_res_t;

endpackage

// ----- design/tnt_ram.sv -----
// Generic simple dual-port RAM with a registered, read-first read port.
// No dependencies.
module tnt_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ----- design/tnt_norm.sv -----
// Iterative vector normalizer: scale, sum of squares, integer root, divides.
// Depends on tnt_pkg.
module tnt_norm import tnt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  vec_t [2:0]   vec,
	output logic         done,
	output fix16_t [2:0] unit
);

	typedef enum logic [6:0] {
		N_IDLE  = 7'b0000001,
		N_SCALE = 7'b0000010,
		N_SQ    = 7'b0000100,
		N_ROOT  = 7'b0001000,
		N_DLD   = 7'b0010000,
		N_DIV   = 7'b0100000,
		N_FIN   = 7'b1000000
	} nstate_t;

	nstate_t st_q;
	logic [2:0][35:0] m_q;
	logic [2:0] neg_q;
	logic [1:0] cnt_q;
	logic [59:0] mul_q;
	logic [61:0] rem_q;
	logic [61:0] root_q;
	logic [60:0] bit_q;
	logic [44:0] num_q;
	logic [14:0] quo_q;
	logic [3:0] qb_q;
	fix16_t [2:0] unit_q;

	logic [35:0] mx;
	logic [35:0] m_sel;
	logic [62:0] trial;
	logic [45:0] dv;
	logic [14:0] quo_nx;
	logic [14:0] quo_cl;
	logic [2:0][35:0] mag;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec[i][35] ? 36'(-vec[i]) : 36'(vec[i]);
		end
		mx = m_q[0];
		if (m_q[1] > mx) mx = m_q[1];
		if (m_q[2] > mx) mx = m_q[2];
		case (cnt_q)
			2'd0: m_sel = m_q[0];
			2'd1: m_sel = m_q[1];
			2'd2: m_sel = m_q[2];
			default: m_sel = '0;
		endcase
		trial = {1'b0, root_q} + 63'(bit_q);
		dv = 46'(root_q[30:0]) << qb_q;
		quo_nx = quo_q;
		if (46'(num_q) >= dv) quo_nx[qb_q] = 1'b1;
		quo_cl = (quo_nx > 15'(UNIT_ONE)) ? 15'(UNIT_ONE) : quo_nx;
	end

	assign done = (st_q == N_FIN);
	assign unit = unit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= N_IDLE;
		end else begin
			case (st_q)
				N_IDLE: if (start) st_q <= (mag == '0) ? N_FIN : N_SCALE;
				N_SCALE: if (mx[35:30] == '0 && mx[29]) st_q <= N_SQ;
				N_SQ: if (cnt_q == 2'd3) st_q <= N_ROOT;
				N_ROOT: if (bit_q[0]) st_q <= N_DLD;
				N_DLD: st_q <= N_DIV;
				N_DIV: if (qb_q == '0) st_q <= (cnt_q == 2'd2) ? N_FIN : N_DLD;
				N_FIN: st_q <= N_IDLE;
				default: st_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			N_IDLE: begin
				m_q <= mag;
				for (int i = 0; i < 3; i++) neg_q[i] <= vec[i][35];
				unit_q <= '0;
			end
			N_SCALE: begin
				if (mx[35:30] != '0) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
				end else if (!mx[29]) begin
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
				end else begin
					cnt_q <= '0;
					rem_q <= '0;
				end
			end
			N_SQ: begin
				mul_q <= m_sel[29:0] * m_sel[29:0];
				if (cnt_q != 2'd0) rem_q <= rem_q + 62'(mul_q);
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					root_q <= '0;
					bit_q <= 61'(1) << 60;
				end
			end
			N_ROOT: begin
				if ({1'b0, rem_q} >= trial) begin
					rem_q <= rem_q - trial[61:0];
					root_q <= (root_q >> 1) + 62'(bit_q);
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) cnt_q <= '0;
			end
			N_DLD: begin
				num_q <= {m_sel[29:0], 14'b0} + 45'(root_q[30:1]);
				quo_q <= '0;
				qb_q <= 4'd14;
			end
			N_DIV: begin
				if (46'(num_q) >= dv) num_q <= num_q - dv[44:0];
				quo_q <= quo_nx;
				qb_q <= qb_q - 4'd1;
				if (qb_q == '0) begin
					unit_q[cnt_q] <= neg_q[cnt_q] ? -16'(quo_cl) : 16'(quo_cl);
					cnt_q <= cnt_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- design/tnt_face.sv -----
// Per-triangle sequencer: edge and uv deltas, a shared 17x17 multiplier for the
// cross product, determinant and tangent, then up to two passes through tnt_norm.
// Depends on tnt_pkg and tnt_norm.
module tnt_face import tnt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  tri_t      tri_in,
	input  logic      normals_en,
	input  logic      tangents_en,
	input  logic      out_free,
	output logic      take,
	output logic      done,
	output face_res_t result
);

	typedef enum logic [6:0] {
		F_IDLE     = 7'b0000001,
		F_MUL      = 7'b0000010,
		F_NRM_GO   = 7'b0000100,
		F_NRM_WAIT = 7'b0001000,
		F_TAN_GO   = 7'b0010000,
		F_TAN_WAIT = 7'b0100000,
		F_DONE     = 7'b1000000
	} fstate_t;

	fstate_t st_q;
	logic signed [16:0] e1_q [3];
	logic signed [16:0] e2_q [3];
	logic signed [16:0] d1u_q, d1v_q, d2u_q, d2v_q;
	logic [3:0] cnt_q;
	logic signed [33:0] mul_q;
	logic signed [33:0] prod_q [14];
	vidx_t [2:0] corner_q;
	fix16_t [2:0] nrm_q;
	fix16_t [2:0] tan_q;

	logic signed [16:0] op_a, op_b;
	vec_t [2:0] vn, vt, nvec;
	logic signed [34:0] det;
	logic nstart, ndone;
	fix16_t [2:0] nunit;

	always_comb begin
		case (cnt_q)
			4'd0:  begin op_a = e1_q[1]; op_b = e2_q[2]; end
			4'd1:  begin op_a = e1_q[2]; op_b = e2_q[1]; end
			4'd2:  begin op_a = e1_q[2]; op_b = e2_q[0]; end
			4'd3:  begin op_a = e1_q[0]; op_b = e2_q[2]; end
			4'd4:  begin op_a = e1_q[0]; op_b = e2_q[1]; end
			4'd5:  begin op_a = e1_q[1]; op_b = e2_q[0]; end
			4'd6:  begin op_a = d1u_q;   op_b = d2v_q;   end
			4'd7:  begin op_a = d1v_q;   op_b = d2u_q;   end
			4'd8:  begin op_a = d2v_q;   op_b = e1_q[0]; end
			4'd9:  begin op_a = d1v_q;   op_b = e2_q[0]; end
			4'd10: begin op_a = d2v_q;   op_b = e1_q[1]; end
			4'd11: begin op_a = d1v_q;   op_b = e2_q[1]; end
			4'd12: begin op_a = d2v_q;   op_b = e1_q[2]; end
			4'd13: begin op_a = d1v_q;   op_b = e2_q[2]; end
			default: begin op_a = '0; op_b = '0; end
		endcase
		det = 35'(prod_q[6]) - 35'(prod_q[7]);
		for (int i = 0; i < 3; i++) begin
			vn[i] = 36'(prod_q[2 * i]) - 36'(prod_q[2 * i + 1]);
			vt[i] = 36'(prod_q[8 + 2 * i]) - 36'(prod_q[9 + 2 * i]);
			if (det < 0) vt[i] = -vt[i];
		end
		nvec = (st_q == F_NRM_GO) ? vn : vt;
	end

	assign take = (st_q == F_IDLE) && start;
	assign nstart = ((st_q == F_NRM_GO) && normals_en) ||
		((st_q == F_TAN_GO) && tangents_en && det != '0);
	assign done = (st_q == F_DONE) && out_free;
	assign result = '{corner: corner_q, nrm: nrm_q, tan: tan_q};

	tnt_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nstart),
		.vec    (nvec),
		.done   (ndone),
		.unit   (nunit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			case (st_q)
				F_IDLE: if (start) st_q <= F_MUL;
				F_MUL: if (cnt_q == 4'd14) st_q <= F_NRM_GO;
				F_NRM_GO: st_q <= nstart ? F_NRM_WAIT : F_TAN_GO;
				F_NRM_WAIT: if (ndone) st_q <= F_TAN_GO;
				F_TAN_GO: st_q <= nstart ? F_TAN_WAIT : F_DONE;
				F_TAN_WAIT: if (ndone) st_q <= F_DONE;
				F_DONE: if (out_free) st_q <= F_IDLE;
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= 17'($signed(tri_in.vert[1].pos[i])) -
						17'($signed(tri_in.vert[0].pos[i]));
					e2_q[i] <= 17'($signed(tri_in.vert[2].pos[i])) -
						17'($signed(tri_in.vert[0].pos[i]));
				end
				// Texture coordinates are stored as {u, v} with u in the upper slot.
				d1u_q <= 17'($signed(tri_in.vert[1].tex[1])) - 17'($signed(tri_in.vert[0].tex[1]));
				d1v_q <= 17'($signed(tri_in.vert[1].tex[0])) - 17'($signed(tri_in.vert[0].tex[0]));
				d2u_q <= 17'($signed(tri_in.vert[2].tex[1])) - 17'($signed(tri_in.vert[0].tex[1]));
				d2v_q <= 17'($signed(tri_in.vert[2].tex[0])) - 17'($signed(tri_in.vert[0].tex[0]));
				corner_q <= tri_in.corner;
				cnt_q <= '0;
			end
			F_MUL: begin
				mul_q <= op_a * op_b;
				if (cnt_q != 4'd0) prod_q[cnt_q - 4'd1] <= mul_q;
				cnt_q <= cnt_q + 4'd1;
			end
			F_NRM_GO: if (!nstart) nrm_q <= '0;
			F_NRM_WAIT: if (ndone) nrm_q <= nunit;
			F_TAN_GO: if (!nstart) tan_q <= '0;
			F_TAN_WAIT: if (ndone) tan_q <= nunit;
			default: ;
		endcase
	end

endmodule

// ----- design/triangle_normal_tangent_engine_top.sv -----
// Top level of the triangle face normal and tangent engine: vertex store,
// corner fetch, configuration registers and the three-item result buffer.
// Depends on tnt_pkg, tnt_ram and tnt_face.
//
//   Channel  Signals                          Direction  Moves
//   req      req_valid / req_ready / req      in         load or triangle item
//   res      res_valid / res_ready / res      out        one corner result item
//   cfg      cfg_we / cfg_index / cfg_wdata   in         register write, no wait
//
// A load item is taken whenever the corner fetch is not reading, so loads
// stream at one item per cycle. A triangle item reads its three corners,
// one after another, from the single read port of the vertex store. The
// face sequencer then takes it, runs the shared multiplier through its
// products, launches each enabled vector into the shared normalizer and
// delivers the result; the tangent is launched only for a nonzero uv
// determinant. A vector in the shared normalizer is scaled, squared and
// summed, taken through the root steps and the divides, and finished; a
// zero-length vector goes straight to the finish. One triangle waits in a
// holding register and one finished triangle sits in the output buffer, so
// fetch, compute and delivery overlap. Reset clears control state only; the
// vertex store is undefined until written. A stalled res channel holds the
// buffer, which in turn stalls the sequencer and then triangle items on req.
module triangle_normal_tangent_engine_top import tnt_pkg::*; #(
	parameter int VERTEX_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_t                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_wdata
);

	localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

	// Corner fetch: each state names the corner whose store data arrives in it.
	typedef enum logic [3:0] {
		FE_IDLE = 4'b0001,
		FE_A    = 4'b0010,
		FE_B    = 4'b0100,
		FE_C    = 4'b1000
	} fetch_t;

	fetch_t fe_q;
	logic normals_en_q, tangents_en_q;
	logic hold_valid_q;
	tri_t hold_q;
	logic [2:0] in_rng_q;
	logic obuf_valid_q;
	logic [1:0] oidx_q;
	face_res_t obuf_q;

	logic acc, acc_tri, acc_load;
	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	vert_t ram_wdata, ram_rdata, rd_vert;
	logic face_take, face_done;
	face_res_t face_res;

	// Loads may follow the last corner read; a triangle also needs the fetch idle and the
	// holding register to be empty, since its fetch will fill it.
	assign req_ready = (fe_q == FE_IDLE || fe_q == FE_C) &&
		(req.kind == KIND_LOAD || (fe_q == FE_IDLE && !hold_valid_q));
	assign acc = req_valid && req_ready;
	assign acc_tri = acc && req.kind == KIND_TRI;
	assign acc_load = acc && req.kind == KIND_LOAD;

	// Slots beyond the store depth are never written and read back as zero.
	assign ram_we = acc_load && (32'(req.vertex_slot) < VERTEX_DEPTH);
	assign ram_waddr = AW'(req.vertex_slot);
	assign ram_wdata = '{pos: {req.pos_z, req.pos_y, req.pos_x}, tex: {req.tex_u, req.tex_v}};
	assign ram_re = acc_tri || fe_q == FE_A || fe_q == FE_B;

	always_comb begin
		case (fe_q)
			FE_A: ram_raddr = AW'(hold_q.corner[1]);
			FE_B: ram_raddr = AW'(hold_q.corner[2]);
			default: ram_raddr = AW'(req.corner_a);
		endcase
		case (fe_q)
			FE_A: rd_vert = in_rng_q[0] ? ram_rdata : '0;
			FE_B: rd_vert = in_rng_q[1] ? ram_rdata : '0;
			default: rd_vert = in_rng_q[2] ? ram_rdata : '0;
		endcase
	end

	tnt_ram #(
		.WIDTH ($bits(vert_t)),
		.DEPTH (VERTEX_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	tnt_face u_face (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (hold_valid_q),
		.tri_in      (hold_q),
		.normals_en  (normals_en_q),
		.tangents_en (tangents_en_q),
		.out_free    (!obuf_valid_q),
		.take        (face_take),
		.done        (face_done),
		.result      (face_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q <= FE_IDLE;
			hold_valid_q <= 1'b0;
			normals_en_q <= 1'b1;
			tangents_en_q <= 1'b1;
			obuf_valid_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			case (fe_q)
				FE_IDLE: if (acc_tri) fe_q <= FE_A;
				FE_A: fe_q <= FE_B;
				FE_B: fe_q <= FE_C;
				FE_C: fe_q <= FE_IDLE;
				default: fe_q <= FE_IDLE;
			endcase

			if (fe_q == FE_C) begin
				hold_valid_q <= 1'b1;
			end else if (face_take) begin
				hold_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_index)
					CFG_NORMALS: normals_en_q <= cfg_wdata;
					CFG_TANGENTS: tangents_en_q <= cfg_wdata;
					default: ;
				endcase
			end

			// Each finished triangle is delivered as three items, corner A first.
			if (face_done) begin
				obuf_valid_q <= 1'b1;
				oidx_q <= '0;
			end else if (res_valid && res_ready) begin
				if (oidx_q == 2'd2) begin
					obuf_valid_q <= 1'b0;
				end else begin
					oidx_q <= oidx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_tri) begin
			hold_q.corner <= {req.corner_c, req.corner_b, req.corner_a};
			in_rng_q[0] <= 32'(req.corner_a) < VERTEX_DEPTH;
			in_rng_q[1] <= 32'(req.corner_b) < VERTEX_DEPTH;
			in_rng_q[2] <= 32'(req.corner_c) < VERTEX_DEPTH;
		end
		case (fe_q)
			FE_A: hold_q.vert[0] <= rd_vert;
			FE_B: hold_q.vert[1] <= rd_vert;
			FE_C: hold_q.vert[2] <= rd_vert;
			default: ;
		endcase
		if (face_done) obuf_q <= face_res;
	end

	always_comb begin
		res_valid = obuf_valid_q;
		case (oidx_q)
			2'd1: res.target_vertex = obuf_q.corner[1];
			2'd2: res.target_vertex = obuf_q.corner[2];
			default: res.target_vertex = obuf_q.corner[0];
		endcase
		res.normal_x = obuf_q.nrm[0];
		res.normal_y = obuf_q.nrm[1];
		res.normal_z = obuf_q.nrm[2];
		res.tangent_x = obuf_q.tan[0];
		res.tangent_y = obuf_q.tan[1];
		res.tangent_z = obuf_q.tan[2];
		res.last_corner = (oidx_q == 2'd2);
	end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the triangle face normal and tangent engine.
// Drives load and triangle items, predicts the three corner results of each
// triangle in fixed point and checks them in order. Depends on tnt_pkg and the top level.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tnt_pkg::*;

	localparam int DEPTH       = 1024;
	localparam int DRAIN_WAIT  = 300;
	localparam int STALL_LIMIT = 20000;
	localparam int REPORT_MAX  = 10;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	res_t                 res;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_NORMALS;
	logic                 cfg_wdata = 1'b0;

	triangle_normal_tangent_engine_top #(.VERTEX_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Items waiting to be sent and corner results waiting to arrive.
	req_t pending_items[$];
	res_t expected_corners[$];

	// Shadow copy of the vertex store and the two enables.
	fix16_t shadow_pos[DEPTH][3];
	fix16_t shadow_tex[DEPTH][2];
	logic   shadow_normals  = 1'b1;
	logic   shadow_tangents = 1'b1;

	// Slots already loaded by generated items; triangles only name these,
	// so an unwritten store entry is never read.
	vidx_t loaded_slots[$];
	bit    slot_loaded[DEPTH];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Scales the vector so its largest magnitude lies in [2^29, 2^30), then
	// divides each component by the floored length with rounding, clamped to one.
	function automatic void normalize(input longint c[3], output fix16_t o[3]);
		longint unsigned m[3], mx, l, q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = c[i] < 0 ? -c[i] : c[i];
			if (m[i] > mx)
				mx = m[i];
		end
		for (int i = 0; i < 3; i++)
			o[i] = '0;
		if (mx == 0)
			return;
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++)
				m[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++)
				m[i] <<= 1;
		end
		l = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * UNIT_ONE + l / 2) / l;
			if (q > UNIT_ONE)
				q = UNIT_ONE;
			o[i] = c[i] < 0 ? -fix16_t'(q) : fix16_t'(q);
		end
	endfunction

	// Updates the shadow store for a load, or queues three corner results.
	function automatic void predict_item(req_t r);
		vidx_t  cn[3];
		longint e1[3], e2[3], v[3];
		longint d1u, d1v, d2u, d2v, det;
		fix16_t nrm[3], tng[3];
		res_t   o;
		if (r.kind == KIND_LOAD) begin
			shadow_pos[r.vertex_slot] = '{r.pos_x, r.pos_y, r.pos_z};
			shadow_tex[r.vertex_slot] = '{r.tex_u, r.tex_v};
			return;
		end
		cn = '{r.corner_a, r.corner_b, r.corner_c};
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(shadow_pos[cn[1]][i]) - longint'(shadow_pos[cn[0]][i]);
			e2[i] = longint'(shadow_pos[cn[2]][i]) - longint'(shadow_pos[cn[0]][i]);
			nrm[i] = '0;
			tng[i] = '0;
		end
		if (shadow_normals) begin
			v[0] = e1[1] * e2[2] - e1[2] * e2[1];
			v[1] = e1[2] * e2[0] - e1[0] * e2[2];
			v[2] = e1[0] * e2[1] - e1[1] * e2[0];
			normalize(v, nrm);
		end
		if (shadow_tangents) begin
			d1u = longint'(shadow_tex[cn[1]][0]) - longint'(shadow_tex[cn[0]][0]);
			d1v = longint'(shadow_tex[cn[1]][1]) - longint'(shadow_tex[cn[0]][1]);
			d2u = longint'(shadow_tex[cn[2]][0]) - longint'(shadow_tex[cn[0]][0]);
			d2v = longint'(shadow_tex[cn[2]][1]) - longint'(shadow_tex[cn[0]][1]);
			det = d1u * d2v - d1v * d2u;
			// A zero uv determinant leaves the tangent at zero.
			if (det != 0) begin
				for (int i = 0; i < 3; i++) begin
					v[i] = d2v * e1[i] - d1v * e2[i];
					if (det < 0)
						v[i] = -v[i];
				end
				normalize(v, tng);
			end
		end
		for (int k = 0; k < 3; k++) begin
			o.target_vertex = cn[k];
			o.normal_x      = nrm[0];
			o.normal_y      = nrm[1];
			o.normal_z      = nrm[2];
			o.tangent_x     = tng[0];
			o.tangent_y     = tng[1];
			o.tangent_z     = tng[2];
			o.last_corner   = (k == 2);
			expected_corners.push_back(o);
		end
	endfunction

	// A load item; the corner fields are don't-care and get random values.
	function automatic void add_load(vidx_t slot, fix16_t x, fix16_t y, fix16_t z,
			fix16_t u, fix16_t v);
		req_t r;
		r = req_t'({$urandom, $urandom, $urandom, $urandom});
		r.kind        = KIND_LOAD;
		r.vertex_slot = slot;
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		r.tex_u = u;
		r.tex_v = v;
		if (!slot_loaded[slot]) begin
			slot_loaded[slot] = 1'b1;
			loaded_slots.push_back(slot);
		end
		pending_items.push_back(r);
	endfunction

	function automatic void add_triangle(vidx_t a, vidx_t b, vidx_t c);
		req_t r;
		r = req_t'({$urandom, $urandom, $urandom, $urandom});
		r.kind     = KIND_TRI;
		r.corner_a = a;
		r.corner_b = b;
		r.corner_c = c;
		pending_items.push_back(r);
	endfunction

	function automatic vidx_t any_loaded();
		return loaded_slots[$urandom_range(loaded_slots.size() - 1)];
	endfunction

	// Random values: mostly full range, sometimes small so that triangles
	// also come out near-degenerate.
	function automatic fix16_t rand_fix();
		return ($urandom_range(3) == 0) ? fix16_t'($signed($urandom_range(64)) - 32)
			: fix16_t'($urandom);
	endfunction

	function automatic void add_random(int count);
		vidx_t a;
		for (int n = 0; n < count; n++) begin
			if (loaded_slots.size() < 3 || $urandom_range(99) < 45) begin
				add_load(vidx_t'($urandom), rand_fix(), rand_fix(), rand_fix(),
					rand_fix(), rand_fix());
			end else begin
				a = any_loaded();
				if ($urandom_range(19) == 0)
					add_triangle(a, a, any_loaded());
				else
					add_triangle(a, any_loaded(), any_loaded());
			end
		end
	endfunction

	// The block is idle once every item is sent and every result is back;
	// the extra cycles cover a load that is still being written.
	task automatic wait_idle();
		wait (pending_items.size() == 0 && !req_valid);
		wait (expected_corners.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NORMALS)
			shadow_normals = val;
		else
			shadow_tangents = val;
	endtask

	task automatic run_phase(int count, int s_idle, int r_idle, logic nrm, logic tng);
		wait_idle();
		write_reg(CFG_NORMALS, nrm);
		write_reg(CFG_TANGENTS, tng);
		@(negedge clk);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		add_random(count);
	endtask

	// Driver: raises valid with the next item and holds it until accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready)
				predict_item(req);
			if (!req_valid || req_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req       <= pending_items.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_corners.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result item %p", res);
				end else begin
					want = expected_corners.pop_front();
					if (res.target_vertex !== want.target_vertex
							|| res.normal_x !== want.normal_x
							|| res.normal_y !== want.normal_y
							|| res.normal_z !== want.normal_z
							|| res.tangent_x !== want.tangent_x
							|| res.tangent_y !== want.tangent_y
							|| res.tangent_z !== want.tangent_z
							|| res.last_corner !== want.last_corner) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("mismatch: expected %p got %p", want, res);
					end
				end
			end
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (res_valid && res_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 36;
		recv_idle_pct = 88;
		// Directed part with the reset settings (both vectors enabled):
		// field extremes, zero-length and collinear triangles, repeated
		// corners, reversed winding for a negative uv determinant.
		add_load(0, 0, 0, 0, 0, 0);
		add_load(1, 16'sh7fff, -16'sh8000, 0, 16'sh7fff, 0);
		add_load(2, -16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000);
		add_load(1023, 256, 512, -768, 4096, -4096);
		add_load(3, 100, 100, 100, 10, 20);
		add_load(4, 200, 200, 200, 20, 40);
		add_load(5, -16'sh8000, -16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff);
		add_load(6, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1, -1);
		add_triangle(0, 1, 2);
		add_triangle(2, 1, 0);
		add_triangle(0, 0, 0);
		add_triangle(0, 1, 1);
		add_triangle(0, 3, 4);
		add_triangle(1023, 0, 1);
		add_triangle(0, 1, 1023);
		add_triangle(5, 6, 2);
		add_triangle(6, 5, 1);
		add_triangle(1023, 1023, 5);
		add_random(150);
		run_phase(140, 88, 36, 1'b0, 1'b1);
		run_phase(80, 0, 0, 1'b1, 1'b0);
		run_phase(30, 0, 0, 1'b0, 1'b0);
		run_phase(20, 0, 0, 1'b1, 1'b1);
		wait_idle();
		if (mismatches == 0 && expected_corners.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
